// ----- hw/rtl/lpfd_pkg.sv -----
// Package for the length-prefixed frame decoder: item codes, result codes,
// the result struct passed from the parser to the top level, and sizes.
// Depends on nothing.
`default_nettype none

package lpfd_pkg;

    localparam int unsigned DEFAULT_PAYLOAD_CAPACITY = 4096;
    localparam int unsigned HDR_BYTES  = 8;
    localparam int unsigned HDR_IDX_W  = 3;
    localparam int unsigned HDR_CNT_W  = 4;

    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned FLEN_W     = 13;
    localparam int unsigned SEQ_W      = 32;

    // Kind of input transaction, carried on s_tuser.
    typedef enum logic [1:0] {
        MODE_FEED    = 2'd0,
        MODE_CONSUME = 2'd1,
        MODE_RESET   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_NEED_MORE = 2'd0,
        STATUS_READY     = 2'd1,
        STATUS_ERROR     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_FLAGS        = 2'd1,
        ERR_TOO_LARGE    = 2'd2,
        ERR_NOT_CONSUMED = 2'd3
    } err_t;

    typedef struct packed {
        logic                valid;
        status_t             status;
        err_t                error_code;
        logic                payload_valid;
        logic [7:0]          payload_byte;
        logic [OFFSET_W-1:0] payload_offset;
        logic [7:0]          frame_type;
        logic [FLEN_W-1:0]   frame_length;
        logic [SEQ_W-1:0]    sequence_number;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpfd_parser.sv -----
// Header capture, payload counting and sticky error tracking of the frame
// decoder. One input transaction is processed per enabled cycle.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_parser #(
    parameter int unsigned PAYLOAD_CAPACITY = lpfd_pkg::DEFAULT_PAYLOAD_CAPACITY
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             item_en,
    input  wire lpfd_pkg::mode_t  item_mode,
    input  wire logic [7:0]       item_byte,
    output lpfd_pkg::result_t     result
);

    localparam int unsigned CNT_W = $clog2(PAYLOAD_CAPACITY + 1);

    logic [7:0]                     hdr_store_reg [lpfd_pkg::HDR_BYTES];
    logic [lpfd_pkg::HDR_CNT_W-1:0] hdr_count_reg, hdr_count_next;
    logic [CNT_W-1:0]               exp_len_reg, exp_len_next;
    logic [CNT_W-1:0]               rcv_count_reg, rcv_count_next;
    logic                           ready_reg, ready_next;
    lpfd_pkg::err_t                 error_reg, error_next;

    logic                           hdr_we;
    logic [15:0]                    hdr_len;
    logic [CNT_W:0]                 rcv_plus;
    logic [31:0]                    rcv_wide;
    logic [31:0]                    exp_wide;
    logic [lpfd_pkg::SEQ_W-1:0]     seq_closing;
    logic [lpfd_pkg::SEQ_W-1:0]     seq_stored;

    assign hdr_len     = {hdr_store_reg[2], hdr_store_reg[3]};
    assign rcv_plus    = {1'b0, rcv_count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign rcv_wide    = 32'(rcv_count_reg);
    assign exp_wide    = 32'(exp_len_reg);
    // On the closing header byte the last sequence byte is still on the input.
    assign seq_closing = {hdr_store_reg[4], hdr_store_reg[5], hdr_store_reg[6], item_byte};
    assign seq_stored  = {hdr_store_reg[4], hdr_store_reg[5], hdr_store_reg[6],
                          hdr_store_reg[7]};

    always_comb begin
        hdr_count_next = hdr_count_reg;
        exp_len_next   = exp_len_reg;
        rcv_count_next = rcv_count_reg;
        ready_next     = ready_reg;
        error_next     = error_reg;
        hdr_we         = 1'b0;
        result         = '0;

        if (item_en) begin
            unique case (item_mode)
                lpfd_pkg::MODE_RESET: begin
                    hdr_count_next = '0;
                    exp_len_next   = '0;
                    rcv_count_next = '0;
                    ready_next     = 1'b0;
                    error_next     = lpfd_pkg::ERR_NONE;
                end
                lpfd_pkg::MODE_CONSUME: begin
                    if (ready_reg) begin
                        hdr_count_next = '0;
                        exp_len_next   = '0;
                        rcv_count_next = '0;
                        ready_next     = 1'b0;
                    end
                end
                lpfd_pkg::MODE_FEED: begin
                    result.valid = 1'b1;
                    priority if (error_reg != lpfd_pkg::ERR_NONE) begin
                        result.status     = lpfd_pkg::STATUS_ERROR;
                        result.error_code = error_reg;
                    end else if (ready_reg) begin
                        error_next        = lpfd_pkg::ERR_NOT_CONSUMED;
                        result.status     = lpfd_pkg::STATUS_ERROR;
                        result.error_code = lpfd_pkg::ERR_NOT_CONSUMED;
                    end else if (hdr_count_reg < lpfd_pkg::HDR_CNT_W'(lpfd_pkg::HDR_BYTES))
                    begin
                        hdr_we         = 1'b1;
                        hdr_count_next = hdr_count_reg + 1'b1;
                        if (hdr_count_reg == lpfd_pkg::HDR_CNT_W'(lpfd_pkg::HDR_BYTES - 1))
                        begin
                            priority if (hdr_store_reg[1] != 8'd0) begin
                                error_next        = lpfd_pkg::ERR_FLAGS;
                                result.status     = lpfd_pkg::STATUS_ERROR;
                                result.error_code = lpfd_pkg::ERR_FLAGS;
                            end else if (17'(hdr_len) > 17'(PAYLOAD_CAPACITY)) begin
                                error_next        = lpfd_pkg::ERR_TOO_LARGE;
                                result.status     = lpfd_pkg::STATUS_ERROR;
                                result.error_code = lpfd_pkg::ERR_TOO_LARGE;
                            end else begin
                                exp_len_next = CNT_W'(hdr_len);
                                if (hdr_len == 16'd0) begin
                                    ready_next             = 1'b1;
                                    result.status          = lpfd_pkg::STATUS_READY;
                                    result.frame_type      = hdr_store_reg[0];
                                    result.frame_length    = '0;
                                    result.sequence_number = seq_closing;
                                end
                            end
                        end
                    end else begin
                        result.payload_valid  = 1'b1;
                        result.payload_byte   = item_byte;
                        result.payload_offset = rcv_wide[lpfd_pkg::OFFSET_W-1:0];
                        rcv_count_next        = rcv_plus[CNT_W-1:0];
                        if (rcv_plus >= {1'b0, exp_len_reg}) begin
                            ready_next             = 1'b1;
                            result.status          = lpfd_pkg::STATUS_READY;
                            result.frame_type      = hdr_store_reg[0];
                            result.frame_length    = exp_wide[lpfd_pkg::FLEN_W-1:0];
                            result.sequence_number = seq_stored;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_count_reg <= '0;
            exp_len_reg   <= '0;
            rcv_count_reg <= '0;
            ready_reg     <= 1'b0;
            error_reg     <= lpfd_pkg::ERR_NONE;
        end else begin
            hdr_count_reg <= hdr_count_next;
            exp_len_reg   <= exp_len_next;
            rcv_count_reg <= rcv_count_next;
            ready_reg     <= ready_next;
            error_reg     <= error_next;
        end
    end

    // Header bytes are read no earlier than the closing header byte, once the first seven have been written.
    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_store_reg[hdr_count_reg[lpfd_pkg::HDR_IDX_W-1:0]] <= item_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/length_prefixed_frame_decoder.sv -----
// Top level of the length-prefixed frame decoder: stream ports, output
// register and assertions. Depends on lpfd_pkg and lpfd_parser.
//
//   Channel  Direction  tdata                         tuser
//   s_       in         data_byte                     mode
//   m_       out        payload and header fields     status, error_code, payload_valid
//
// One input transaction is taken per cycle while s_tready is high; its result, if any, appears on m_
// in the next cycle from the output register. The parser's state update and
// the result register are the only sequential stages.
// s_tready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous) empties the output register and clears
// the decoder's counters and flags, the sticky error included, but not the header store.
`default_nettype none

module length_prefixed_frame_decoder #(
    parameter int unsigned PAYLOAD_CAPACITY = lpfd_pkg::DEFAULT_PAYLOAD_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [7:0] payload_byte, [19:8] payload_offset,
                                        // [27:20] frame_type, [40:28] frame_length,
                                        // [72:41] sequence_number, [79:73] zero
    output logic [4:0]       m_tuser    // [1:0] status, [3:2] error_code, [4] payload_valid
);

    logic              accept;
    lpfd_pkg::result_t result;
    lpfd_pkg::result_t out_reg;
    logic              out_valid_reg, out_valid_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    lpfd_parser #(
        .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_en   (accept),
        .item_mode (lpfd_pkg::mode_t'(s_tuser)),
        .item_byte (s_tdata),
        .result    (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = result.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.sequence_number, out_reg.frame_length,
                       out_reg.frame_type, out_reg.payload_offset, out_reg.payload_byte};
    assign m_tuser  = {out_reg.payload_valid, out_reg.error_code, out_reg.status};

`ifndef ASSERT_OFF
    // Every accepted feed transaction produces exactly one result next cycle.
    a_feed_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == lpfd_pkg::MODE_FEED) |=> m_tvalid)
        else $error("feed transaction produced no result");

    // Consume, reset and ignored transactions leave the output empty.
    a_control_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser != lpfd_pkg::MODE_FEED) |=> !m_tvalid)
        else $error("control transaction produced a result");

    // An error code is reported exactly when the status is error.
    a_error_code_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_reg.status == lpfd_pkg::STATUS_ERROR) ==
                      (out_reg.error_code != lpfd_pkg::ERR_NONE)))
        else $error("error code does not match status");

    // A payload byte is never echoed together with an error.
    a_payload_not_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.payload_valid |-> (out_reg.status != lpfd_pkg::STATUS_ERROR))
        else $error("payload byte echoed with error status");
`endif

endmodule

`default_nettype wire
